/* rtl/core/rlsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlsc_pkg
// Shared types and codes for the reference-counted LRU slot cache.
// ----------------------------------------------------------------------------
package rlsc_pkg;

   typedef enum logic [1:0] {
      CMD_INC   = 2'd0,
      CMD_DEC   = 2'd1,
      CMD_INS   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_REPLACED = 3'd1,
      ST_MISSING  = 3'd2,
      ST_NO_SPACE = 3'd3,
      ST_IGNORED  = 3'd4
   } status_type;

   localparam logic CSR_CAPACITY      = 1'b0;
   localparam logic CSR_FIRST_VISIBLE = 1'b1;

   localparam int CHAR_W = 21;
   localparam int FONT_W = 16;
   localparam int CAP_W  = 9;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_SCAN,
      S_SCAN_WAIT,
      S_DECIDE,
      S_LINK_RD,
      S_LINK_WAIT,
      S_LINK_FIX,
      S_LINK_FIX2,
      S_EVICT_RD,
      S_EVICT_WAIT,
      S_RESULT
   } state_type;

endpackage

/* rtl/core/rlsc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlsc_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module rlsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/core/refcounted_lru_slot_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_lru_slot_cache
// Slot cache keyed by (character, font) with reference counts and an
// age-ordered dead list used to pick eviction victims.
// ----------------------------------------------------------------------------
// Each transaction scans the key memory one slot a cycle over all SLOTS
// entries; the single read port of the key memory sets that figure. After
// the scan come S_SCAN_WAIT, S_DECIDE and S_RESULT; a revived entry passes
// S_LINK_FIX too and an eviction S_EVICT_WAIT and S_LINK_FIX, the longest
// path. The next request is taken at the edge after the result transaction
// at the earliest. A decrement below first_visible and a clear command
// answer at once, without a scan. After reset and after every capacity write
// or clear command a clearing pass walks every entry of the valid memory,
// during which no request is taken. Valid bits, keys, counts and dead-list
// links live in RAMs with a registered read; the dead list is a doubly
// linked list patched with one read and up to one write per link memory.
// ----------------------------------------------------------------------------
module refcounted_lru_slot_cache #(
   parameter int SLOTS    = 256,
   parameter int REF_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: cmd[1:0], char_code[22:2], font_id[38:23], zero fill to 40
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // rsp_tdata: status[2:0], slot[10:3], ref_count[26:11],
   // evicted_char[47:27], evicted_font[63:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [20:0] csr_data
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = AW + 1;
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

   // configuration
   logic [8:0]  capacity_ff;
   logic [20:0] first_vis_ff;

   // request latch
   rlsc_pkg::cmd_type       cmd_ff;
   logic [20:0]             char_ff;
   logic [15:0]             font_ff;

   rlsc_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic                    found_ff, found_in;
   logic [AW-1:0]           hit_ff, hit_in;
   logic                    hasfree_ff, hasfree_in;
   logic [AW-1:0]           free_ff, free_in;
   logic [AW-1:0]           chk_ff;
   logic                    chk_vld_ff;
   logic [AW-1:0]           head_ff, head_in;
   logic [AW-1:0]           tail_ff, tail_in;
   logic [CW-1:0]           dcount_ff, dcount_in;
   logic [REF_BITS-1:0]     refs_ff, refs_in;
   logic [AW-1:0]           tgt_ff, tgt_in;
   logic [AW-1:0]           lp_ff, lp_in, ln_ff, ln_in;
   logic                    rsp_vld_ff;
   logic [63:0]             rsp_data_ff, rsp_data_in;
   logic                    rsp_load;

   // effective capacity
   logic [CW-1:0] cap_eff;
   always_comb begin
      if (int'(capacity_ff) > SLOTS) cap_eff = SLOTS_C;
      else cap_eff = CW'(capacity_ff);
   end

   // memories
   logic                vld_we, vld_wd, vld_rd;
   logic [AW-1:0]       vld_wa, rd_a;
   logic                key_we;
   logic [36:0]         key_rd;
   logic                ref_we;
   logic [REF_BITS-1:0] ref_wd, ref_rd;
   logic [AW-1:0]       ref_wa;
   logic                prv_we, nxt_we;
   logic [AW-1:0]       prv_wa, prv_wd, nxt_wa, nxt_wd, prv_rd, nxt_rd;

   rlsc_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_vld (
      .clock(clock), .wr_en(vld_we), .wr_addr(vld_wa), .wr_data(vld_wd),
      .rd_addr(rd_a), .rd_data(vld_rd));
   rlsc_ram #(.WIDTH(37), .DEPTH(SLOTS)) u_key (
      .clock(clock), .wr_en(key_we), .wr_addr(tgt_ff), .wr_data({font_ff, char_ff}),
      .rd_addr(rd_a), .rd_data(key_rd));
   rlsc_ram #(.WIDTH(REF_BITS), .DEPTH(SLOTS)) u_ref (
      .clock(clock), .wr_en(ref_we), .wr_addr(ref_wa), .wr_data(ref_wd),
      .rd_addr(rd_a), .rd_data(ref_rd));
   rlsc_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_prv (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(rd_a), .rd_data(prv_rd));
   rlsc_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_nxt (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(rd_a), .rd_data(nxt_rd));

   wire cfg_wr   = csr_valid && csr_ready;
   wire req_acc  = req_tvalid && req_tready;
   wire idx_last = (idx_ff == SLOTS_C - CW'(1));

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == rlsc_pkg::S_IDLE) && !rsp_vld_ff;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // scan compare on the entry read last cycle
   wire chk_in_cap = ({1'b0, chk_ff} < cap_eff);
   wire chk_hit    = chk_vld_ff && chk_in_cap && vld_rd &&
                     key_rd == {font_ff, char_ff};
   wire chk_free   = chk_vld_ff && chk_in_cap && !vld_rd;

   function automatic logic [63:0] pack_rsp(rlsc_pkg::status_type st,
         logic [7:0] sl, logic [15:0] rc, logic [20:0] ec, logic [15:0] ef);
      pack_rsp = {ef, ec, rc, sl, 3'(st)};
   endfunction

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      hit_in      = hit_ff;
      hasfree_in  = hasfree_ff;
      free_in     = free_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      dcount_in   = dcount_ff;
      refs_in     = refs_ff;
      tgt_in      = tgt_ff;
      lp_in       = lp_ff;
      ln_in       = ln_ff;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      rd_a        = idx_ff[AW-1:0];
      vld_we = 1'b0; vld_wa = idx_ff[AW-1:0]; vld_wd = 1'b0;
      key_we = 1'b0;
      ref_we = 1'b0; ref_wa = tgt_ff; ref_wd = refs_ff;
      prv_we = 1'b0; prv_wa = tgt_ff; prv_wd = tail_ff;
      nxt_we = 1'b0; nxt_wa = tail_ff; nxt_wd = tgt_ff;

      if (chk_hit && !found_ff) begin
         found_in = 1'b1;
         hit_in   = chk_ff;
      end
      if (chk_free && !hasfree_ff) begin
         hasfree_in = 1'b1;
         free_in    = chk_ff;
      end

      case (state_ff)
         rlsc_pkg::S_IDLE: begin
            if (req_acc) begin
               idx_in     = '0;
               found_in   = 1'b0;
               hasfree_in = 1'b0;
               if (rlsc_pkg::cmd_type'(req_tdata[1:0]) == rlsc_pkg::CMD_CLEAR) begin
                  state_in = rlsc_pkg::S_CLEAR;
                  rsp_load = 1'b1;
                  rsp_data_in = pack_rsp(rlsc_pkg::ST_OK, '0, '0, '0, '0);
                  head_in = '0; tail_in = '0; dcount_in = '0;
               end else if (rlsc_pkg::cmd_type'(req_tdata[1:0]) == rlsc_pkg::CMD_DEC
                            && req_tdata[22:2] < first_vis_ff) begin
                  rsp_load = 1'b1;
                  rsp_data_in = pack_rsp(rlsc_pkg::ST_IGNORED, '0, '0, '0, '0);
               end else begin
                  state_in = rlsc_pkg::S_SCAN;
               end
            end
         end
         rlsc_pkg::S_CLEAR: begin
            vld_we = 1'b1;
            vld_wd = 1'b0;
            idx_in = idx_ff + CW'(1);
            if (idx_last) state_in = rlsc_pkg::S_IDLE;
         end
         rlsc_pkg::S_SCAN: begin
            idx_in = idx_ff + CW'(1);
            if (idx_last) state_in = rlsc_pkg::S_SCAN_WAIT;
         end
         rlsc_pkg::S_SCAN_WAIT: begin
            // last compare lands this cycle; read counts at the hit next
            state_in = rlsc_pkg::S_DECIDE;
            rd_a     = (chk_hit && !found_ff) ? chk_ff : hit_ff;
         end
         rlsc_pkg::S_DECIDE: begin
            // ref_rd/prv_rd/nxt_rd hold the hit slot's entry
            rd_a   = hit_ff;
            tgt_in = hit_ff;
            lp_in  = prv_rd;
            ln_in  = nxt_rd;
            case (cmd_ff)
               rlsc_pkg::CMD_INC: begin
                  if (!found_ff) begin
                     rsp_load = 1'b1;
                     rsp_data_in = pack_rsp(rlsc_pkg::ST_MISSING, '0, '0, '0, '0);
                     state_in = rlsc_pkg::S_IDLE;
                  end else begin
                     refs_in = (ref_rd == REF_MAX) ? ref_rd : ref_rd + REF_BITS'(1);
                     state_in = (ref_rd == '0) ? rlsc_pkg::S_LINK_FIX
                                               : rlsc_pkg::S_RESULT;
                  end
               end
               rlsc_pkg::CMD_DEC: begin
                  if (!found_ff) begin
                     rsp_load = 1'b1;
                     rsp_data_in = pack_rsp(rlsc_pkg::ST_MISSING, '0, '0, '0, '0);
                     state_in = rlsc_pkg::S_IDLE;
                  end else if (ref_rd == '0) begin
                     rsp_load = 1'b1;
                     rsp_data_in = pack_rsp(rlsc_pkg::ST_IGNORED, 8'(hit_ff), '0,
                                            '0, '0);
                     state_in = rlsc_pkg::S_IDLE;
                  end else begin
                     refs_in = ref_rd - REF_BITS'(1);
                     state_in = rlsc_pkg::S_RESULT;
                     if (ref_rd == REF_BITS'(1)) begin
                        // append to the newest end of the dead list
                        if (dcount_ff == '0) begin
                           head_in = hit_ff;
                        end else begin
                           nxt_we = 1'b1; nxt_wa = tail_ff; nxt_wd = hit_ff;
                           prv_we = 1'b1; prv_wa = hit_ff; prv_wd = tail_ff;
                        end
                        tail_in   = hit_ff;
                        dcount_in = dcount_ff + CW'(1);
                     end
                  end
               end
               default: begin
                  if (found_ff) begin
                     rsp_load = 1'b1;
                     rsp_data_in = pack_rsp(rlsc_pkg::ST_IGNORED, 8'(hit_ff),
                                            16'(ref_rd), '0, '0);
                     state_in = rlsc_pkg::S_IDLE;
                  end else if (hasfree_ff) begin
                     tgt_in  = free_ff;
                     refs_in = REF_BITS'(1);
                     state_in = rlsc_pkg::S_RESULT;
                  end else if (dcount_ff != '0) begin
                     tgt_in  = head_ff;
                     rd_a    = head_ff;
                     state_in = rlsc_pkg::S_EVICT_WAIT;
                  end else begin
                     rsp_load = 1'b1;
                     rsp_data_in = pack_rsp(rlsc_pkg::ST_NO_SPACE, '0, '0, '0, '0);
                     state_in = rlsc_pkg::S_IDLE;
                  end
               end
            endcase
         end
         rlsc_pkg::S_EVICT_WAIT: begin
            // key, links of the victim are on the read ports
            rd_a  = tgt_ff;
            lp_in = prv_rd;
            ln_in = nxt_rd;
            rsp_data_in = pack_rsp(rlsc_pkg::ST_REPLACED, 8'(tgt_ff), 16'd1,
                                   key_rd[20:0], key_rd[36:21]);
            refs_in = REF_BITS'(1);
            state_in = rlsc_pkg::S_LINK_FIX;
         end
         rlsc_pkg::S_LINK_FIX: begin
            // unlink tgt_ff: fix head side / prev's next, tail side / next's prev
            if (dcount_ff != '0) begin
               if (tgt_ff == head_ff) head_in = ln_ff;
               else begin
                  nxt_we = 1'b1; nxt_wa = lp_ff; nxt_wd = ln_ff;
               end
               if (tgt_ff == tail_ff) tail_in = lp_ff;
               else begin
                  prv_we = 1'b1; prv_wa = ln_ff; prv_wd = lp_ff;
               end
               dcount_in = dcount_ff - CW'(1);
            end
            state_in = rlsc_pkg::S_RESULT;
         end
         rlsc_pkg::S_RESULT: begin
            ref_we = 1'b1;
            ref_wa = tgt_ff;
            ref_wd = refs_ff;
            rsp_load = 1'b1;
            if (cmd_ff == rlsc_pkg::CMD_INS) begin
               vld_we = 1'b1; vld_wa = tgt_ff; vld_wd = 1'b1;
               key_we = 1'b1;
               if (!hasfree_ff) begin
                  rsp_data_in = {rsp_data_ff[63:27], 16'd1, 8'(tgt_ff),
                                 3'(rlsc_pkg::ST_REPLACED)};
               end else begin
                  rsp_data_in = pack_rsp(rlsc_pkg::ST_OK, 8'(tgt_ff), 16'd1, '0, '0);
               end
            end else begin
               rsp_data_in = pack_rsp(rlsc_pkg::ST_OK, 8'(tgt_ff), 16'(refs_ff),
                                      '0, '0);
            end
            state_in = rlsc_pkg::S_IDLE;
         end
         default: state_in = rlsc_pkg::S_IDLE;
      endcase

      // a capacity write empties the cache and restarts the clearing pass
      if (cfg_wr && csr_index == rlsc_pkg::CSR_CAPACITY) begin
         state_in  = rlsc_pkg::S_CLEAR;
         idx_in    = '0;
         head_in   = '0;
         tail_in   = '0;
         dcount_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlsc_pkg::S_CLEAR;
         idx_ff       <= '0;
         capacity_ff  <= 9'd256;
         first_vis_ff <= 21'd32;
         head_ff      <= '0;
         tail_ff      <= '0;
         dcount_ff    <= '0;
         rsp_vld_ff   <= 1'b0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         hasfree_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         dcount_ff  <= dcount_in;
         found_ff   <= found_in;
         hasfree_ff <= hasfree_in;
         chk_vld_ff <= (state_ff == rlsc_pkg::S_SCAN);
         if (rsp_load) rsp_vld_ff <= 1'b1;
         else if (rsp_tready) rsp_vld_ff <= 1'b0;
         if (cfg_wr) begin
            if (csr_index == rlsc_pkg::CSR_CAPACITY) begin
               capacity_ff <= csr_data[8:0];
            end else begin
               first_vis_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_ff      <= idx_ff[AW-1:0];
      hit_ff      <= hit_in;
      free_ff     <= free_in;
      refs_ff     <= refs_in;
      tgt_ff      <= tgt_in;
      lp_ff       <= lp_in;
      ln_ff       <= ln_in;
      rsp_data_ff <= rsp_data_in;
      if (req_acc) begin
         cmd_ff  <= rlsc_pkg::cmd_type'(req_tdata[1:0]);
         char_ff <= req_tdata[22:2];
         font_ff <= req_tdata[38:23];
      end
   end

   a_dead_bound: assert property (@(posedge clock) disable iff (reset)
      dcount_ff <= SLOTS_C) else $error("dead count above slot count");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !req_tready) else $error("request taken with result pending");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      state_ff == rlsc_pkg::S_CLEAR |-> dcount_ff == '0)
      else $error("dead list not empty during clear");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the reference-counted LRU slot cache. Commands go in
// with random gaps and results come back under random backpressure, both off
// in calm phases; a behavioral copy of the slot table, dead list and registers
// predicts every result, which is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
   import rlsc_pkg::*;

   localparam int SLOT_N   = 256;
   localparam int CNT_BITS = 16;
   localparam logic [15:0] CNT_MAX = 16'((1 << CNT_BITS) - 1);

   typedef struct packed {
      status_type  status;
      logic [7:0]  slot;
      logic [15:0] refs;
      logic [20:0] ev_char;
      logic [15:0] ev_font;
   } lookup_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [20:0] csr_data;

   refcounted_lru_slot_cache #(
      .SLOTS    (SLOT_N),
      .REF_BITS (CNT_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------
   // Slot table shadow
   // ------------------------------------------------------------------
   logic [8:0]  cap_reg;
   logic [20:0] vis_reg;
   bit          sh_valid [SLOT_N];
   logic [20:0] sh_char  [SLOT_N];
   logic [15:0] sh_font  [SLOT_N];
   logic [15:0] sh_refs  [SLOT_N];
   logic [7:0]  sh_prev  [SLOT_N];
   logic [7:0]  sh_next  [SLOT_N];
   logic [7:0]  dead_head;
   logic [7:0]  dead_tail;
   int          dead_cnt;

   lookup_result_type result_q[$];
   int                error_cnt;
   bit                calm;

   function automatic int slots_used();
      return (cap_reg > SLOT_N) ? SLOT_N : int'(cap_reg);
   endfunction

   function automatic void wipe_table();
      foreach (sh_valid[i]) sh_valid[i] = 1'b0;
      dead_head = '0;
      dead_tail = '0;
      dead_cnt  = 0;
   endfunction

   function automatic int find_slot(logic [20:0] c, logic [15:0] f);
      for (int i = 0; i < slots_used(); i++)
         if (sh_valid[i] && sh_char[i] == c && sh_font[i] == f) return i;
      return -1;
   endfunction

   function automatic void dead_push(logic [7:0] s);
      if (dead_cnt == 0) begin
         dead_head = s;
      end else begin
         sh_next[dead_tail] = s;
         sh_prev[s] = dead_tail;
      end
      dead_tail = s;
      dead_cnt++;
   endfunction

   function automatic void dead_unlink(logic [7:0] s);
      logic [7:0] p;
      logic [7:0] n;
      if (dead_cnt == 0) return;
      p = sh_prev[s];
      n = sh_next[s];
      if (s == dead_head) dead_head = n;
      else sh_next[p] = n;
      if (s == dead_tail) dead_tail = p;
      else sh_prev[n] = p;
      dead_cnt--;
   endfunction

   function automatic lookup_result_type lookup_step(cmd_type cmd, logic [20:0] c,
                                                     logic [15:0] f);
      lookup_result_type r;
      int k;
      int fs;
      r = '{status: ST_OK, slot: '0, refs: '0, ev_char: '0, ev_font: '0};
      case (cmd)
         CMD_INC: begin
            k = find_slot(c, f);
            if (k < 0) begin
               r.status = ST_MISSING;
            end else begin
               r.slot = 8'(k);
               if (sh_refs[k] == 0) dead_unlink(8'(k));
               if (sh_refs[k] < CNT_MAX) sh_refs[k]++;
               r.refs = sh_refs[k];
            end
         end
         CMD_DEC: begin
            if (c < vis_reg) begin
               r.status = ST_IGNORED;
            end else begin
               k = find_slot(c, f);
               if (k < 0) begin
                  r.status = ST_MISSING;
               end else begin
                  r.slot = 8'(k);
                  if (sh_refs[k] == 0) begin
                     r.status = ST_IGNORED;
                  end else begin
                     sh_refs[k]--;
                     if (sh_refs[k] == 0) dead_push(8'(k));
                  end
                  r.refs = sh_refs[k];
               end
            end
         end
         CMD_INS: begin
            k = find_slot(c, f);
            if (k >= 0) begin
               r.status = ST_IGNORED;
               r.slot   = 8'(k);
               r.refs   = sh_refs[k];
            end else begin
               fs = -1;
               for (int i = 0; i < slots_used(); i++)
                  if (!sh_valid[i]) begin
                     fs = i;
                     break;
                  end
               if (fs >= 0) begin
                  r.slot = 8'(fs);
               end else if (dead_cnt > 0) begin
                  r.slot = dead_head;
                  dead_unlink(dead_head);
                  r.ev_char = sh_char[r.slot];
                  r.ev_font = sh_font[r.slot];
                  r.status  = ST_REPLACED;
               end else begin
                  r.status = ST_NO_SPACE;
               end
               if (r.status != ST_NO_SPACE) begin
                  sh_valid[r.slot] = 1'b1;
                  sh_char[r.slot]  = c;
                  sh_font[r.slot]  = f;
                  sh_refs[r.slot]  = 16'd1;
                  r.refs = 16'd1;
               end
            end
         end
         default: wipe_table();
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------
   function automatic int draw_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   task automatic send_item(cmd_type cmd, logic [20:0] c, logic [15:0] f);
      int gap;
      lookup_result_type pred;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, f, c, cmd};
      #1;
      while (!req_tready) begin
         @(negedge clock);
         #1;
      end
      @(posedge clock);
      pred = lookup_step(cmd, c, f);
      result_q.insert(result_q.size(), pred);
   endtask

   // Hold off until every outstanding result has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [20:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      #1;
      while (!csr_ready) begin
         @(negedge clock);
         #1;
      end
      @(posedge clock);
      if (idx == CSR_CAPACITY) begin
         cap_reg = value[8:0];
         wipe_table();
      end else begin
         vis_reg = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   int stall_left;
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 75) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 9) < 9) ? $urandom_range(0, 3)
                                                  : $urandom_range(15, 70);
      end
   end

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("ERROR %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
      error_cnt++;
   endtask

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_q.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(rsp_tdata[26:0]), 32'd0);
         end else begin
            want = result_q.pop_front();
            if (rsp_tdata[2:0] !== want.status)
               report_mismatch("status", 32'(rsp_tdata[2:0]), 32'(want.status));
            if (rsp_tdata[10:3] !== want.slot)
               report_mismatch("slot", 32'(rsp_tdata[10:3]), 32'(want.slot));
            if (rsp_tdata[26:11] !== want.refs)
               report_mismatch("ref_count", 32'(rsp_tdata[26:11]), 32'(want.refs));
            if (rsp_tdata[47:27] !== want.ev_char)
               report_mismatch("evicted_char", 32'(rsp_tdata[47:27]),
                               32'(want.ev_char));
            if (rsp_tdata[63:48] !== want.ev_font)
               report_mismatch("evicted_font", 32'(rsp_tdata[63:48]),
                               32'(want.ev_font));
         end
      end
   end

   // ------------------------------------------------------------------
   // Key pool: most traffic hits a few keys so entries live, die and return
   // ------------------------------------------------------------------
   logic [20:0] pool_char [24];
   logic [15:0] pool_font [24];
   int          pool_n;

   function automatic void fill_pool(int n);
      pool_n = n;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: pool_char[i] = 21'($urandom_range(0, 64));
            1: pool_char[i] = 21'($urandom);
            2: pool_char[i] = 21'($urandom_range(1114000, 1114111));
            default: pool_char[i] = 21'($urandom_range(32, 2000));
         endcase
         pool_font[i] = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 3));
      end
   endfunction

   task automatic random_item();
      logic [20:0] c;
      logic [15:0] f;
      int r;
      cmd_type cmd;
      int k;
      if ($urandom_range(0, 9) < 8) begin
         k = $urandom_range(0, pool_n - 1);
         c = pool_char[k];
         f = pool_font[k];
      end else begin
         c = 21'($urandom);
         f = 16'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 36) cmd = CMD_INC;
      else if (r < 70) cmd = CMD_DEC;
      else if (r < 98) cmd = CMD_INS;
      else cmd = CMD_CLEAR;
      send_item(cmd, c, f);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      calm = 1'b1;
      write_reg(CSR_CAPACITY, 21'd2);
      send_item(CMD_INS, 21'd100, 16'd7);        // slot 0
      send_item(CMD_INS, 21'd100, 16'd7);        // already present
      send_item(CMD_INS, 21'h1FFFFF, 16'hFFFF);  // slot 1, all ones
      send_item(CMD_INS, 21'd0, 16'd0);          // full, nothing dead
      send_item(CMD_DEC, 21'd100, 16'd7);        // dies
      send_item(CMD_DEC, 21'd100, 16'd7);        // already dead
      send_item(CMD_INC, 21'd100, 16'd8);        // missing key
      send_item(CMD_DEC, 21'd5, 16'd7);          // below visible
      send_item(CMD_DEC, 21'd101, 16'd7);        // missing on decrement
      send_item(CMD_DEC, 21'h1FFFFF, 16'hFFFF);  // dies, newest
      send_item(CMD_INS, 21'd0, 16'd0);          // evicts oldest dead
      send_item(CMD_INC, 21'h1FFFFF, 16'hFFFF);  // revive from dead
      send_item(CMD_DEC, 21'h1FFFFF, 16'hFFFF);
      send_item(CMD_DEC, 21'd0, 16'd0);          // ignored, below visible
      send_item(CMD_INS, 21'd55, 16'd1);         // evicts
      send_item(CMD_CLEAR, 21'd0, 16'd0);
      send_item(CMD_INS, 21'd55, 16'd1);
      calm = 1'b0;
   endtask

   task automatic test_counting();
      write_reg(CSR_CAPACITY, 21'd1);
      send_item(CMD_INS, 21'd40, 16'd2);
      repeat (40) send_item(CMD_INC, 21'd40, 16'd2);
      send_item(CMD_DEC, 21'd40, 16'd2);
      send_item(CMD_INC, 21'd40, 16'd2);
   endtask

   task automatic test_register_extremes();
      write_reg(CSR_CAPACITY, 21'd0);
      send_item(CMD_INS, 21'd77, 16'd3);
      send_item(CMD_INC, 21'd77, 16'd3);
      write_reg(CSR_FIRST_VISIBLE, 21'h1FFFFF);
      write_reg(CSR_CAPACITY, 21'h1FF);
      send_item(CMD_INS, 21'd77, 16'd3);
      send_item(CMD_DEC, 21'd77, 16'd3);
      send_item(CMD_DEC, 21'h1FFFFE, 16'd3);
      write_reg(CSR_FIRST_VISIBLE, 21'd0);
      send_item(CMD_DEC, 21'd77, 16'd3);
      send_item(CMD_DEC, 21'd0, 16'd0);
   endtask

   task automatic test_random();
      int caps [8] = '{1, 3, 8, 2, 16, 256, 511, 5};
      for (int p = 0; p < 8; p++) begin
         write_reg(CSR_CAPACITY, 21'(caps[p]));
         case (p % 3)
            0: write_reg(CSR_FIRST_VISIBLE, 21'($urandom_range(0, 64)));
            1: write_reg(CSR_FIRST_VISIBLE, 21'd32);
            default: write_reg(CSR_FIRST_VISIBLE, 21'($urandom));
         endcase
         fill_pool((caps[p] + 4 > 24) ? 24 : caps[p] + 4);
         calm = (p == 3);
         for (int n = 0; n < 210; n++) begin
            if (n == 100 && p == 5) drain();
            random_item();
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_CAPACITY;
      csr_data   = '0;
      error_cnt  = 0;
      calm       = 1'b0;
      cap_reg    = 9'd256;
      vis_reg    = 21'd32;
      wipe_table();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_counting();
      test_register_extremes();
      test_random();

      drain();
      repeat (400) @(posedge clock);
      if (error_cnt == 0) begin
         $display("refcounted_lru_slot_cache: match");
      end else begin
         $display("refcounted_lru_slot_cache: mismatch");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("refcounted_lru_slot_cache: mismatch");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/rlsc_pkg.sv
rtl/core/rlsc_ram.sv
rtl/core/refcounted_lru_slot_cache.sv
dv/tb_top.sv
